// ----- sv/jpdr_pkg.sv -----
// ----------------------------------------------------------------------------
// jpdr_pkg
// Shared types, codes and angle constants for the delta-R jet classifier.
// ----------------------------------------------------------------------------
package jpdr_pkg;

    localparam int ANGLE_FRAC_BITS_DEFAULT = 12;
    localparam int RADIUS_FRAC_BITS        = 24;

    // pi in Q2.30
    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    localparam logic [31:0]        RADIUS_SQ_RESET   = 32'd2684355;
    localparam logic signed [31:0] PHOTON_CODE_RESET = 32'sd22;

    localparam logic [1:0] FUNC_EVENT    = 2'd0;
    localparam logic [1:0] FUNC_JET      = 2'd1;
    localparam logic [1:0] FUNC_PARTICLE = 2'd2;
    localparam logic [1:0] FUNC_NOP      = 2'd3;

    localparam logic [1:0] CLASS_PHOTON     = 2'd0;
    localparam logic [1:0] CLASS_NEAR_LEAD  = 2'd1;
    localparam logic [1:0] CLASS_NEAR_SUB   = 2'd2;
    localparam logic [1:0] CLASS_OTHER      = 2'd3;

    localparam int         CFG_INDEX_W     = 2;
    localparam logic [1:0] CFG_RADIUS_SQ   = 2'd0;
    localparam logic [1:0] CFG_PHOTON_CODE = 2'd1;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [15:0] eta;
        logic signed [15:0] phi;
        logic [15:0]        pt;
        logic signed [31:0] particle_code;
    } in_item_t;

    typedef struct packed {
        logic [1:0] color_class;
        logic       leading_found;
        logic       subleading_found;
    } out_item_t;

    // pi rounded to frac fraction bits
    function automatic int pi_fx(input int frac);
        return int'((PI_Q30 + (64'd1 << (29 - frac))) >> (30 - frac));
    endfunction

    // pi/2 rounded to frac fraction bits
    function automatic int half_pi_fx(input int frac);
        return int'((PI_Q30 + (64'd1 << (30 - frac))) >> (31 - frac));
    endfunction

endpackage

// ----- sv/jet_particle_delta_r_classifier_unit.sv -----
// ----------------------------------------------------------------------------
// jet_particle_delta_r_classifier_unit
// Event-based photon/jet/particle classifier using squared delta-R matching.
// ----------------------------------------------------------------------------
// Takes one transaction per cycle on the input channel while in_stall is
// low. Each item is held in an input register; when it advances, a single
// pass of logic (wrap, two subtractions, two squares per held jet, and
// compares) updates the event state and, for particle items, loads the
// result register that drives the output. The sustained rate is one item
// per clock while the output side does not stall. Input stall rises only
// while a particle item waits behind a result that the output side has
// stalled. Event-start, jet and no-op items give no result. Configuration
// writes are always ready and take effect at the next edge.
// ----------------------------------------------------------------------------
module jet_particle_delta_r_classifier_unit #(
    parameter int ANGLE_FRAC_BITS = jpdr_pkg::ANGLE_FRAC_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  jpdr_pkg::in_item_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output jpdr_pkg::out_item_t                 out_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [jpdr_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [31:0]                         cfg_data
);
    import jpdr_pkg::*;

    localparam int ANG_W  = 20;
    localparam int SQ_W   = 2 * ANG_W;
    localparam int SUM_W  = SQ_W + 1;
    localparam int SH     = RADIUS_FRAC_BITS - 2 * ANGLE_FRAC_BITS;
    localparam int SUM_SH = (SH >= 0) ? SH : 0;
    localparam int RAD_SH = (SH < 0) ? -SH : 0;
    localparam int CMP_W  = ((SUM_W + SUM_SH) > (32 + RAD_SH)) ?
                            (SUM_W + SUM_SH) : (32 + RAD_SH);

    localparam logic signed [ANG_W-1:0] PI_FX      = ANG_W'(pi_fx(ANGLE_FRAC_BITS));
    localparam logic signed [ANG_W-1:0] TWO_PI_FX  = ANG_W'(2 * pi_fx(ANGLE_FRAC_BITS));
    localparam logic signed [ANG_W-1:0] HALF_PI_FX = ANG_W'(half_pi_fx(ANGLE_FRAC_BITS));

    function automatic logic signed [ANG_W-1:0] wrap_once(input logic signed [ANG_W-1:0] d);
        if (d < -PI_FX)
            return d + TWO_PI_FX;
        if (d > PI_FX)
            return d - TWO_PI_FX;
        return d;
    endfunction

    function automatic logic near_jet(
        input logic               valid,
        input logic signed [15:0] jeta,
        input logic signed [15:0] jphi,
        input logic signed [15:0] peta,
        input logic signed [15:0] pphi,
        input logic [31:0]        rad
    );
        logic signed [ANG_W-1:0] je;
        logic signed [ANG_W-1:0] jp;
        logic signed [ANG_W-1:0] de;
        logic signed [ANG_W-1:0] dp;
        logic [SQ_W-1:0]         de_sq;
        logic [SQ_W-1:0]         dp_sq;
        logic [CMP_W-1:0]        dist_sq;
        logic [CMP_W-1:0]        lim;
        logic                    in_range;
        je       = ANG_W'(jeta);
        jp       = ANG_W'(jphi);
        de       = ANG_W'(peta) - je;
        dp       = wrap_once(ANG_W'(pphi) - jp);
        de_sq    = SQ_W'(de) * SQ_W'(de);
        dp_sq    = SQ_W'(dp) * SQ_W'(dp);
        dist_sq  = (CMP_W'(de_sq) + CMP_W'(dp_sq)) << SUM_SH;
        lim      = CMP_W'(rad) << RAD_SH;
        in_range = (je >= -PI_FX) && (je <= PI_FX) && (jp >= 0) && (jp <= TWO_PI_FX);
        return valid && in_range && (dist_sq < lim);
    endfunction

    logic [31:0]        radius_sq_reg;
    logic signed [31:0] photon_code_reg;

    logic               in_valid_reg, in_valid_next;
    in_item_t           in_item_reg;

    logic signed [15:0] photon_azimuth_reg, photon_azimuth_next;
    logic [15:0]        lead_momentum_reg, lead_momentum_next;
    logic signed [15:0] lead_eta_reg, lead_eta_next;
    logic signed [15:0] lead_azimuth_reg, lead_azimuth_next;
    logic               lead_valid_reg, lead_valid_next;
    logic [15:0]        sub_momentum_reg, sub_momentum_next;
    logic signed [15:0] sub_eta_reg, sub_eta_next;
    logic signed [15:0] sub_azimuth_reg, sub_azimuth_next;
    logic               sub_valid_reg, sub_valid_next;

    logic               out_valid_reg, out_valid_next;
    out_item_t          out_item_reg, out_item_next;

    logic                    is_particle;
    logic                    advance;
    logic signed [ANG_W-1:0] photon_diff;
    logic                    jet_keep;
    logic                    near_lead;
    logic                    near_sub;

    assign is_particle = (in_item_reg.func == FUNC_PARTICLE);
    assign advance     = in_valid_reg && (!is_particle || !out_valid_reg || !out_stall);
    assign in_stall    = in_valid_reg && !advance;
    assign cfg_ready   = 1'b1;
    assign out_valid   = out_valid_reg;
    assign out_data    = out_item_reg;

    assign photon_diff = wrap_once(ANG_W'(photon_azimuth_reg) - ANG_W'(in_item_reg.phi));
    assign jet_keep    = !photon_azimuth_reg[15] &&
                         ((photon_diff < -HALF_PI_FX) || (photon_diff > HALF_PI_FX));
    assign near_lead   = near_jet(lead_valid_reg, lead_eta_reg, lead_azimuth_reg,
                                  in_item_reg.eta, in_item_reg.phi, radius_sq_reg);
    assign near_sub    = near_jet(sub_valid_reg, sub_eta_reg, sub_azimuth_reg,
                                  in_item_reg.eta, in_item_reg.phi, radius_sq_reg);

    always_comb
    begin
        in_valid_next       = in_stall ? 1'b1 : in_valid;
        photon_azimuth_next = photon_azimuth_reg;
        lead_momentum_next  = lead_momentum_reg;
        lead_eta_next       = lead_eta_reg;
        lead_azimuth_next   = lead_azimuth_reg;
        lead_valid_next     = lead_valid_reg;
        sub_momentum_next   = sub_momentum_reg;
        sub_eta_next        = sub_eta_reg;
        sub_azimuth_next    = sub_azimuth_reg;
        sub_valid_next      = sub_valid_reg;
        out_valid_next      = out_valid_reg && out_stall;
        out_item_next       = out_item_reg;

        if (advance)
        begin
            case (in_item_reg.func)
                FUNC_EVENT:
                begin
                    photon_azimuth_next = in_item_reg.phi;
                    lead_momentum_next  = '0;
                    lead_eta_next       = '0;
                    lead_azimuth_next   = '0;
                    lead_valid_next     = 1'b0;
                    sub_momentum_next   = '0;
                    sub_eta_next        = '0;
                    sub_azimuth_next    = '0;
                    sub_valid_next      = 1'b0;
                end
                FUNC_JET:
                begin
                    if (jet_keep)
                    begin
                        if (in_item_reg.pt > lead_momentum_reg)
                        begin
                            sub_momentum_next  = lead_momentum_reg;
                            sub_eta_next       = lead_eta_reg;
                            sub_azimuth_next   = lead_azimuth_reg;
                            sub_valid_next     = lead_valid_reg;
                            lead_momentum_next = in_item_reg.pt;
                            lead_eta_next      = in_item_reg.eta;
                            lead_azimuth_next  = in_item_reg.phi;
                            lead_valid_next    = 1'b1;
                        end
                        else if (in_item_reg.pt > sub_momentum_reg)
                        begin
                            sub_momentum_next = in_item_reg.pt;
                            sub_eta_next      = in_item_reg.eta;
                            sub_azimuth_next  = in_item_reg.phi;
                            sub_valid_next    = 1'b1;
                        end
                    end
                end
                FUNC_PARTICLE:
                begin
                    out_valid_next                 = 1'b1;
                    out_item_next.leading_found    = lead_valid_reg;
                    out_item_next.subleading_found = sub_valid_reg;
                    if (in_item_reg.particle_code == photon_code_reg)
                        out_item_next.color_class = CLASS_PHOTON;
                    else if (near_lead)
                        out_item_next.color_class = CLASS_NEAR_LEAD;
                    else if (near_sub)
                        out_item_next.color_class = CLASS_NEAR_SUB;
                    else
                        out_item_next.color_class = CLASS_OTHER;
                end
                FUNC_NOP:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_sq_reg      <= RADIUS_SQ_RESET;
            photon_code_reg    <= PHOTON_CODE_RESET;
            in_valid_reg       <= 1'b0;
            photon_azimuth_reg <= '0;
            lead_momentum_reg  <= '0;
            lead_eta_reg       <= '0;
            lead_azimuth_reg   <= '0;
            lead_valid_reg     <= 1'b0;
            sub_momentum_reg   <= '0;
            sub_eta_reg        <= '0;
            sub_azimuth_reg    <= '0;
            sub_valid_reg      <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_RADIUS_SQ:   radius_sq_reg   <= cfg_data;
                    CFG_PHOTON_CODE: photon_code_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            in_valid_reg       <= in_valid_next;
            photon_azimuth_reg <= photon_azimuth_next;
            lead_momentum_reg  <= lead_momentum_next;
            lead_eta_reg       <= lead_eta_next;
            lead_azimuth_reg   <= lead_azimuth_next;
            lead_valid_reg     <= lead_valid_next;
            sub_momentum_reg   <= sub_momentum_next;
            sub_eta_reg        <= sub_eta_next;
            sub_azimuth_reg    <= sub_azimuth_next;
            sub_valid_reg      <= sub_valid_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall)
            in_item_reg <= in_data;
        out_item_reg <= out_item_next;
    end

    // Event start clears both held jets.
    a_event_clears: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (in_item_reg.func == FUNC_EVENT) |=> !lead_valid_reg && !sub_valid_reg)
        else $error("event start did not clear held jets");

    // A subleading jet is never held without a leading one.
    a_sub_needs_lead: assert property (@(posedge clk) disable iff (!rst_n)
        sub_valid_reg |-> lead_valid_reg && (sub_momentum_reg <= lead_momentum_reg))
        else $error("subleading jet outranks or lacks a leader");

    // Leading valid tracks a nonzero leading momentum.
    a_lead_momentum: assert property (@(posedge clk) disable iff (!rst_n)
        lead_valid_reg == (lead_momentum_reg != '0))
        else $error("leading valid out of step with momentum");

    // A particle that advances always loads a result.
    a_particle_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance && is_particle |=> out_valid_reg)
        else $error("particle item lost its result");

endmodule
